// File: hw/rtl/swcfa_pkg.sv
// -----------------------------------------------------------------------------
// swcfa_pkg
// Shared types and constants for the sliding window first-above block.
// -----------------------------------------------------------------------------
package swcfa_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int ADDR_W        = $clog2(MAX_POSITIONS);
   localparam int VAL_W         = 11;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   typedef logic [VAL_W-1:0]  val_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // register index
   typedef enum logic {
      REG_WINDOW_LENGTH = 1'b0,
      REG_ACTIVE_COUNT  = 1'b1
   } reg_idx_type;

   // item action codes
   typedef enum logic {
      ACT_TOGGLE = 1'b0,
      ACT_QUERY  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TOG_RD,
      ST_TOG_WR,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_DONE
   } state_type;

   // marker memory control
   typedef struct packed {
      logic     we;
      addr_type waddr;
      logic     wdata;
      addr_type raddr_a;
      addr_type raddr_b;
   } ram_ctl_type;

endpackage

// File: hw/rtl/swcfa_if.sv
// -----------------------------------------------------------------------------
// swcfa channel interfaces
// Valid/ready channels for request items and response items.
// -----------------------------------------------------------------------------
interface swcfa_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   swcfa_pkg::val_type position;
   swcfa_pkg::val_type threshold;
   modport source (output valid, action, position, threshold, input ready);
   modport sink   (input valid, action, position, threshold, output ready);
endinterface

interface swcfa_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   swcfa_pkg::val_type first_index;
   modport source (output valid, found, first_index, input ready);
   modport sink   (input valid, found, first_index, output ready);
endinterface

// File: hw/rtl/swcfa_ram.sv
// -----------------------------------------------------------------------------
// swcfa_ram
// Marker bit memory: one write port, two registered read ports.
// -----------------------------------------------------------------------------
module swcfa_ram (
   input  logic                   clock,
   input  swcfa_pkg::ram_ctl_type ctl,
   output logic                   rdata_a,
   output logic                   rdata_b
);

   logic mem [swcfa_pkg::MAX_POSITIONS];
   logic rdata_a_ff;
   logic rdata_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata_a_ff <= mem[ctl.raddr_a];
      rdata_b_ff <= mem[ctl.raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: hw/rtl/sliding_window_count_first_above_top.sv
// -----------------------------------------------------------------------------
// sliding_window_count_first_above_top
// Marker row with windowed counts; answers first position above a threshold.
// -----------------------------------------------------------------------------
// Usage:
//  req_ch carries items: a toggle flips the marker at a position (no
//  response), a query returns on rsp_ch the first position in 1..active_count
//  whose window count exceeds the threshold, or found = 0.
//  csr_* is an APB-style port: window_length at 0x0, active_count at 0x4.
//  Write registers only while the block is idle.
//  A toggle holds the block while it is accepted, read and written back;
//  an out-of-range toggle is dropped and the next item can transfer at once.
//  A query walks the positions through one counter, each position taking
//  a memory read, then an add/compare; the walk stops at the position found
//  or, when none is found, after position active_count (at most 1024). The
//  next item can transfer as soon as the response register is loaded.
//  One item is in work at a time; req_ch.ready is high only when idle.
//  After reset a clearing pass zeroes the marker memory;
//  no item is accepted during it, register writes are.
//  The response sits in an output register; a stalled receiver holds a
//  finished query in the done state until the register frees up.
// -----------------------------------------------------------------------------
module sliding_window_count_first_above_top (
   input  logic                                 clock,
   input  logic                                 reset,
   swcfa_req_if.sink                            req_ch,
   swcfa_rsp_if.source                          rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swcfa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swcfa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swcfa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int VW = swcfa_pkg::VAL_W;
   localparam int AW = swcfa_pkg::ADDR_W;

   swcfa_pkg::state_type   state_ff, state_in;
   swcfa_pkg::val_type     wlen_ff, acnt_ff;
   swcfa_pkg::val_type     pos_ff, pos_in;
   swcfa_pkg::val_type     thr_ff, thr_in;
   swcfa_pkg::val_type     cnt_ff, cnt_in;
   swcfa_pkg::addr_type    clr_ff, clr_in;
   logic                   hit_ff, hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   swcfa_pkg::val_type     rsp_idx_ff, rsp_idx_in;
   swcfa_pkg::ram_ctl_type ram_ctl;
   logic                   rd_a, rd_b;
   logic                   csr_wr;
   swcfa_pkg::reg_idx_type csr_idx;
   swcfa_pkg::val_type     n_pos, d_len, pm1, pmd;
   logic                   tail_on, rsp_free, req_xfer;
   swcfa_pkg::val_type     cnt_next;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = swcfa_pkg::reg_idx_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         swcfa_pkg::REG_WINDOW_LENGTH: csr_prdata[VW-1:0] = wlen_ff;
         swcfa_pkg::REG_ACTIVE_COUNT:  csr_prdata[VW-1:0] = acnt_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= VW'(1);
         acnt_ff <= VW'(swcfa_pkg::MAX_POSITIONS);
      end else if (csr_wr) begin
         if (csr_idx == swcfa_pkg::REG_WINDOW_LENGTH) begin
            wlen_ff <= csr_pwdata[VW-1:0];
         end else begin
            acnt_ff <= csr_pwdata[VW-1:0];
         end
      end
   end

   // effective sizes and scan addresses
   assign n_pos   = (acnt_ff > VW'(swcfa_pkg::MAX_POSITIONS))
                    ? VW'(swcfa_pkg::MAX_POSITIONS) : acnt_ff;
   assign d_len   = (wlen_ff == '0) ? VW'(1) : wlen_ff;
   assign pm1     = pos_ff - VW'(1);
   assign pmd     = pos_ff - d_len - VW'(1);
   assign tail_on = pos_ff > d_len;
   assign cnt_next = cnt_ff + VW'(rd_a) - VW'(tail_on & rd_b);
   assign rsp_free = ~rsp_valid_ff | rsp_ch.ready;
   assign req_xfer = req_ch.valid & req_ch.ready;

   swcfa_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swcfa_pkg::ST_CLEAR: begin
            if (clr_ff == '1) state_in = swcfa_pkg::ST_IDLE;
         end
         swcfa_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_ch.action == swcfa_pkg::ACT_QUERY) begin
                  state_in = swcfa_pkg::ST_SCAN_RD;
               end else if (req_ch.position >= VW'(1) && req_ch.position <= n_pos) begin
                  state_in = swcfa_pkg::ST_TOG_RD;
               end
            end
         end
         swcfa_pkg::ST_TOG_RD:  state_in = swcfa_pkg::ST_TOG_WR;
         swcfa_pkg::ST_TOG_WR:  state_in = swcfa_pkg::ST_IDLE;
         swcfa_pkg::ST_SCAN_RD: begin
            state_in = (pos_ff > n_pos) ? swcfa_pkg::ST_DONE : swcfa_pkg::ST_SCAN_EV;
         end
         swcfa_pkg::ST_SCAN_EV: begin
            state_in = (cnt_next > thr_ff) ? swcfa_pkg::ST_DONE : swcfa_pkg::ST_SCAN_RD;
         end
         swcfa_pkg::ST_DONE: begin
            if (rsp_free) state_in = swcfa_pkg::ST_IDLE;
         end
         default: state_in = swcfa_pkg::ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      ram_ctl         = '0;
      ram_ctl.raddr_a = pm1[AW-1:0];
      ram_ctl.raddr_b = pmd[AW-1:0];
      req_ch.ready    = 1'b0;
      pos_in          = pos_ff;
      thr_in          = thr_ff;
      cnt_in          = cnt_ff;
      hit_in          = hit_ff;
      clr_in          = clr_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ch.ready;
      rsp_found_in    = rsp_found_ff;
      rsp_idx_in      = rsp_idx_ff;
      unique case (state_ff)
         swcfa_pkg::ST_CLEAR: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = clr_ff;
            ram_ctl.wdata = 1'b0;
            clr_in        = clr_ff + AW'(1);
         end
         swcfa_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_xfer) begin
               pos_in = (req_ch.action == swcfa_pkg::ACT_QUERY) ? VW'(1) : req_ch.position;
               thr_in = req_ch.threshold;
               cnt_in = '0;
               hit_in = 1'b0;
            end
         end
         swcfa_pkg::ST_TOG_RD: begin
         end
         swcfa_pkg::ST_TOG_WR: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = pm1[AW-1:0];
            ram_ctl.wdata = ~rd_a;
         end
         swcfa_pkg::ST_SCAN_RD: begin
         end
         swcfa_pkg::ST_SCAN_EV: begin
            cnt_in = cnt_next;
            if (cnt_next > thr_ff) begin
               hit_in = 1'b1;
            end else begin
               pos_in = pos_ff + VW'(1);
            end
         end
         swcfa_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_idx_in   = hit_ff ? pos_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swcfa_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      thr_ff       <= thr_in;
      cnt_ff       <= cnt_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.first_index = rsp_idx_ff;

   // checks
   a_no_ready_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == swcfa_pkg::ST_CLEAR |-> !req_ch.ready)
      else $error("item accepted during clearing pass");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_idx_ff == '0)
      else $error("not-found response with nonzero index");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_idx_ff != '0)
      else $error("found response with zero index");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == swcfa_pkg::ST_SCAN_EV || state_ff == swcfa_pkg::ST_SCAN_RD
      |-> !ram_ctl.we)
      else $error("marker write during scan");

endmodule
